FILE: hw/rtl/asfp_pkg.sv
// Package for the payload packetizer: field widths, header byte codes,
// packing limits and the divider handshake types. No dependencies.
`default_nettype none

package asfp_pkg;

	localparam int SN_W     = 7;
	localparam int BYTE_W   = 8;
	localparam int FSIZE_W  = 32;
	localparam int FTIME_W  = 63;
	localparam int OFF_W    = 16;
	localparam int MS_W     = 32;
	localparam int PCOUNT_W = 7;

	localparam int STREAM_COUNT_DEF = 128;

	localparam logic [OFF_W-1:0] PKT_SIZE_RESET = 16'd4096;
	localparam logic [OFF_W-1:0] MIN_PKT_SIZE   = 16'd64;

	localparam int PKT_HDR_LEN  = 14;
	localparam int FRAG_HDR_LEN = 17;
	localparam int CLOSE_ROOM   = 18;

	localparam logic [7:0] STREAM_FLAG  = 8'h80;
	localparam logic [7:0] FRAG_FLAGS   = 8'h08;
	localparam logic [7:0] PKT_FLAGS    = 8'h82;
	localparam logic [7:0] PKT_PROPS    = 8'h11;
	localparam logic [7:0] PKT_LEN_TYPE = 8'h5D;
	localparam logic [7:0] PAYLOAD_FLAG = 8'h80;

	localparam int MS_DIV     = 1000;
	localparam int MS_REM_W   = 10;
	localparam int DIG_W      = 4;
	localparam int DIV_NUM_W  = 64;
	localparam int DIV_STEPS  = DIV_NUM_W / DIG_W;
	localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic                 start;
		logic                 neg;
		logic [DIV_NUM_W-1:0] mag;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [MS_W-1:0] ms;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/asfp_frame_if.sv
// Frame byte channel of the packetizer: valid, ready and one frame byte
// with its stream, frame size and timestamp. Depends on asfp_pkg.
`default_nettype none

interface asfp_frame_if;
	logic                          valid;
	logic                          ready;
	logic [asfp_pkg::SN_W-1:0]     stream_number;
	logic [asfp_pkg::BYTE_W-1:0]   data_byte;
	logic [asfp_pkg::FSIZE_W-1:0]  frame_size;
	logic [asfp_pkg::FTIME_W-1:0]  frame_time;

	modport source (
		output valid, stream_number, data_byte, frame_size, frame_time,
		input  ready
	);
	modport sink (
		input  valid, stream_number, data_byte, frame_size, frame_time,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/asfp_write_if.sv
// Packet buffer write channel of the packetizer: valid, ready, offset,
// byte value and the packet done flag. Depends on asfp_pkg.
`default_nettype none

interface asfp_write_if;
	logic                        valid;
	logic                        ready;
	logic [asfp_pkg::OFF_W-1:0]  packet_offset;
	logic [asfp_pkg::BYTE_W-1:0] out_byte;
	logic                        packet_done;

	modport source (
		output valid, packet_offset, out_byte, packet_done,
		input  ready
	);
	modport sink (
		input  valid, packet_offset, out_byte, packet_done,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/asfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module asfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/asfp_div1000.sv
// Radix-16 divider of a 64-bit magnitude by 1000 for the millisecond time,
// one digit per cycle, signed low 32 bits of the quotient. Uses asfp_pkg.
`default_nettype none

module asfp_div1000 (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire asfp_pkg::div_req_t req,
	output      asfp_pkg::div_rsp_t rsp
);

	localparam int T_W = asfp_pkg::MS_REM_W + asfp_pkg::DIG_W;

	logic [asfp_pkg::DIV_NUM_W-1:0]  num_q;
	logic [asfp_pkg::MS_REM_W-1:0]   rem_q;
	logic [asfp_pkg::MS_W-1:0]       quo_q;
	logic                            neg_q;
	logic [asfp_pkg::DIV_STEP_W-1:0] steps_q;

	logic [T_W-1:0]                  part;
	logic [T_W-1:0]                  sub_v;
	logic [asfp_pkg::DIG_W-1:0]      digit;

	always_comb begin
		part  = {rem_q, num_q[asfp_pkg::DIV_NUM_W-1 -: asfp_pkg::DIG_W]};
		sub_v = '0;
		digit = '0;
		for (int i = 1; i < (1 << asfp_pkg::DIG_W); i++) begin
			if (part >= T_W'(i * asfp_pkg::MS_DIV)) begin
				digit = asfp_pkg::DIG_W'(i);
				sub_v = T_W'(i * asfp_pkg::MS_DIV);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (req.start) begin
			steps_q <= asfp_pkg::DIV_STEP_W'(asfp_pkg::DIV_STEPS);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.mag;
			neg_q <= req.neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (steps_q != '0) begin
			num_q <= {num_q[asfp_pkg::DIV_NUM_W-asfp_pkg::DIG_W-1:0],
				{asfp_pkg::DIG_W{1'b0}}};
			rem_q <= asfp_pkg::MS_REM_W'(part - sub_v);
			quo_q <= {quo_q[asfp_pkg::MS_W-asfp_pkg::DIG_W-1:0], digit};
		end
	end

	assign rsp.done = (steps_q == '0);
	assign rsp.ms   = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/asf_payload_packetizer.sv
// Payload packetizer: frame bytes in, packet buffer byte writes out.
// Items are registered in the item stage, writes in the output register.
// Throughput: one write per cycle unless writes.ready or the divide stalls;
// a new fragment adds 17 header writes and waits on the 16-step divide by
// 1000 for its time field, a packet close adds pad+14 writes.
// Reset clears all control state and the per-stream sequence valid bits at once.
`default_nettype none

module asf_payload_packetizer #(
	parameter int STREAM_COUNT = asfp_pkg::STREAM_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       packet_size_we,
	input  wire logic [asfp_pkg::OFF_W-1:0] packet_size_wdata,
	asfp_frame_if.sink                      frames,
	asfp_write_if.source                    writes
);

	localparam int IDX_W   = $clog2(STREAM_COUNT);
	localparam int SN_VALS = 1 << asfp_pkg::SN_W;
	localparam int OFF_W   = asfp_pkg::OFF_W;

	localparam logic [4:0] MS_POS_LO  = 5'd11;
	localparam logic [4:0] MS_POS_HI  = 5'd14;
	localparam logic [4:0] LEN_POS_LO = 5'd15;
	localparam logic [4:0] FRAG_LAST  = 5'(asfp_pkg::FRAG_HDR_LEN - 1);
	localparam logic [4:0] PKH_LAST   = 5'(asfp_pkg::PKT_HDR_LEN - 1);

	typedef enum logic [1:0] {
		PH_FRAG,
		PH_DATA,
		PH_PAD,
		PH_PKH
	} phase_t;

	// stream index table
	logic [IDX_W-1:0] idx_tab [SN_VALS];
	for (genvar g = 0; g < SN_VALS; g++) begin : g_idx
		assign idx_tab[g] = IDX_W'(g % STREAM_COUNT);
	end

	// item stage
	logic                            valid_s1;
	logic                            first_s1;
	logic [asfp_pkg::SN_W-1:0]       sn_s1;
	logic [7:0]                      db_s1;
	logic [asfp_pkg::FSIZE_W-1:0]    fsize_s1;
	logic [asfp_pkg::FTIME_W-1:0]    ftime_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            vld_s1;
	logic                            fwd_s1;
	logic [7:0]                      fwd_val_s1;

	// sequencer and packet state
	phase_t                          phase_q;
	logic [4:0]                      cnt_q;
	logic [OFF_W-1:0]                off_q;
	logic [4:0]                      pad_q;
	logic [7:0]                      seq_q;
	logic [asfp_pkg::MS_W-1:0]       pkt_ms_q;
	logic                            opened_q;
	logic [OFF_W-1:0]                packet_size_q;
	logic                            packet_open_q;
	logic [OFF_W-1:0]                bytes_used_q;
	logic [asfp_pkg::PCOUNT_W-1:0]   payload_count_q;
	logic [asfp_pkg::FTIME_W-1:0]    first_time_q;
	logic                            first_seen_q;
	logic [asfp_pkg::FSIZE_W-1:0]    frame_offset_q;
	logic [OFF_W-1:0]                fragment_left_q;
	logic [STREAM_COUNT-1:0]         vbits_q;

	// output register
	logic                            out_valid_q;
	logic [OFF_W-1:0]                out_off_q;
	logic [7:0]                      out_byte_q;
	logic                            out_done_q;

	logic [IDX_W-1:0]                idx_in;
	logic                            accept;
	logic [7:0]                      ram_rdata;
	logic                            seq_we;
	logic [7:0]                      seq_wdata;

	logic [OFF_W-1:0]                size_eff;
	logic [7:0]                      seq_mux;
	logic [7:0]                      seq_cur;
	logic                            new_frag;
	logic [OFF_W-1:0]                bu_start;
	logic [asfp_pkg::FSIZE_W-1:0]    remain;
	logic [OFF_W:0]                  bu_need;
	logic [OFF_W-1:0]                room;
	logic [OFF_W-1:0]                len_new;
	logic [asfp_pkg::FTIME_W-1:0]    ft_eff;

	phase_t                          ph_cur;
	logic [4:0]                      cnt_cur;
	logic [OFF_W-1:0]                off_cur;
	logic                            stall;
	logic                            have_write;
	logic                            emit;
	logic                            last_write;
	logic                            item_last;

	logic [OFF_W-1:0]                bu_new;
	logic [OFF_W-1:0]                fl_dec;
	logic                            frame_end;
	logic [OFF_W-1:0]                fl_new;
	logic [OFF_W-1:0]                pad_full;
	logic                            close;

	logic [OFF_W-1:0]                wr_off;
	logic [7:0]                      wr_byte;
	logic                            wr_done;

	asfp_pkg::div_req_t              div_req;
	asfp_pkg::div_rsp_t              div_rsp;

	assign idx_in = idx_tab[frames.stream_number];

	asfp_ram #(
		.WIDTH (8),
		.DEPTH (STREAM_COUNT)
	) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (idx_s1),
		.wdata (seq_wdata),
		.re    (accept),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	asfp_div1000 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		size_eff = (packet_size_q < asfp_pkg::MIN_PKT_SIZE) ?
			asfp_pkg::MIN_PKT_SIZE : packet_size_q;
		seq_mux  = fwd_s1 ? fwd_val_s1 : (vld_s1 ? ram_rdata : 8'd0);
		seq_cur  = first_s1 ? seq_mux : seq_q;
		new_frag = (fragment_left_q == '0);
		bu_start = (new_frag && !packet_open_q) ?
			OFF_W'(asfp_pkg::PKT_HDR_LEN) : bytes_used_q;

		remain  = (frame_offset_q < fsize_s1) ? (fsize_s1 - frame_offset_q) :
			asfp_pkg::FSIZE_W'(1);
		bu_need = {1'b0, bu_start} + (OFF_W+1)'(asfp_pkg::CLOSE_ROOM);
		room    = ({1'b0, size_eff} >= bu_need) ?
			(size_eff - bu_start - OFF_W'(asfp_pkg::FRAG_HDR_LEN)) : OFF_W'(1);
		len_new = (remain < asfp_pkg::FSIZE_W'(room)) ? remain[OFF_W-1:0] : room;

		ft_eff        = first_seen_q ? first_time_q : ftime_s1;
		div_req.start = valid_s1 && first_s1 && new_frag;
		div_req.neg   = (ftime_s1 < ft_eff);
		div_req.mag   = div_req.neg ?
			asfp_pkg::DIV_NUM_W'(ft_eff - ftime_s1) :
			asfp_pkg::DIV_NUM_W'(ftime_s1 - ft_eff);

		ph_cur  = first_s1 ? (new_frag ? PH_FRAG : PH_DATA) : phase_q;
		cnt_cur = first_s1 ? 5'd0 : cnt_q;
		off_cur = first_s1 ? bu_start : off_q;

		stall      = (ph_cur == PH_FRAG) && (cnt_cur >= MS_POS_LO) &&
			(cnt_cur <= MS_POS_HI) && !div_rsp.done;
		have_write = valid_s1 && !stall;
		emit       = have_write && (!out_valid_q || writes.ready);

		bu_new    = off_cur + 1'b1;
		fl_dec    = (fragment_left_q == '0) ? '0 : (fragment_left_q - 1'b1);
		frame_end = ({1'b0, frame_offset_q} + (asfp_pkg::FSIZE_W+1)'(1)) >=
			{1'b0, fsize_s1};
		fl_new    = frame_end ? '0 : fl_dec;
		pad_full  = (size_eff > bu_new) ? (size_eff - bu_new) : '0;
		close     = (fl_new == '0) && (pad_full < OFF_W'(asfp_pkg::CLOSE_ROOM));

		seq_we    = emit && (ph_cur == PH_DATA) && frame_end;
		seq_wdata = seq_cur + 8'd1;
	end

	always_comb begin
		wr_off     = off_cur;
		wr_byte    = 8'h00;
		wr_done    = 1'b0;
		last_write = 1'b0;
		case (ph_cur)
			PH_FRAG: begin
				case (cnt_cur)
					5'd0:    wr_byte = asfp_pkg::STREAM_FLAG | 8'(sn_s1);
					5'd1:    wr_byte = seq_cur;
					5'd2:    wr_byte = frame_offset_q[7:0];
					5'd3:    wr_byte = frame_offset_q[15:8];
					5'd4:    wr_byte = frame_offset_q[23:16];
					5'd5:    wr_byte = frame_offset_q[31:24];
					5'd6:    wr_byte = asfp_pkg::FRAG_FLAGS;
					5'd7:    wr_byte = fsize_s1[7:0];
					5'd8:    wr_byte = fsize_s1[15:8];
					5'd9:    wr_byte = fsize_s1[23:16];
					5'd10:   wr_byte = fsize_s1[31:24];
					5'd11:   wr_byte = div_rsp.ms[7:0];
					5'd12:   wr_byte = div_rsp.ms[15:8];
					5'd13:   wr_byte = div_rsp.ms[23:16];
					5'd14:   wr_byte = div_rsp.ms[31:24];
					5'd15:   wr_byte = fragment_left_q[7:0];
					5'd16:   wr_byte = fragment_left_q[15:8];
					default: wr_byte = 8'h00;
				endcase
			end
			PH_DATA: begin
				wr_byte    = db_s1;
				last_write = !close;
			end
			PH_PAD: begin
				wr_byte = 8'h00;
			end
			PH_PKH: begin
				wr_off = OFF_W'(cnt_cur);
				case (cnt_cur)
					5'd0:    wr_byte = asfp_pkg::PKT_FLAGS;
					5'd3:    wr_byte = asfp_pkg::PKT_PROPS;
					5'd4:    wr_byte = asfp_pkg::PKT_LEN_TYPE;
					5'd5:    wr_byte = 8'(pad_q);
					5'd7:    wr_byte = pkt_ms_q[7:0];
					5'd8:    wr_byte = pkt_ms_q[15:8];
					5'd9:    wr_byte = pkt_ms_q[23:16];
					5'd10:   wr_byte = pkt_ms_q[31:24];
					5'd13:   wr_byte = asfp_pkg::PAYLOAD_FLAG | 8'(payload_count_q);
					default: wr_byte = 8'h00;
				endcase
				wr_done    = (cnt_cur == PKH_LAST);
				last_write = (cnt_cur == PKH_LAST);
			end
			default: begin
				wr_byte = 8'h00;
			end
		endcase
	end

	assign item_last    = emit && last_write;
	assign frames.ready = !valid_s1 || item_last;
	assign accept       = frames.valid && frames.ready;

	assign writes.valid         = out_valid_q;
	assign writes.packet_offset = out_off_q;
	assign writes.out_byte      = out_byte_q;
	assign writes.packet_done   = out_done_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			sn_s1    <= frames.stream_number;
			db_s1    <= frames.data_byte;
			fsize_s1 <= frames.frame_size;
			ftime_s1 <= frames.frame_time;
			idx_s1   <= idx_in;
		end
		if (emit) begin
			out_off_q  <= wr_off;
			out_byte_q <= wr_byte;
			out_done_q <= wr_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			first_s1        <= 1'b0;
			vld_s1          <= 1'b0;
			fwd_s1          <= 1'b0;
			fwd_val_s1      <= '0;
			phase_q         <= PH_FRAG;
			cnt_q           <= '0;
			off_q           <= '0;
			pad_q           <= '0;
			seq_q           <= '0;
			pkt_ms_q        <= '0;
			opened_q        <= 1'b0;
			packet_size_q   <= asfp_pkg::PKT_SIZE_RESET;
			packet_open_q   <= 1'b0;
			bytes_used_q    <= '0;
			payload_count_q <= '0;
			first_time_q    <= '0;
			first_seen_q    <= 1'b0;
			frame_offset_q  <= '0;
			fragment_left_q <= '0;
			vbits_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (packet_size_we) begin
				packet_size_q <= packet_size_wdata;
			end

			first_s1 <= accept;
			if (accept) begin
				valid_s1   <= 1'b1;
				vld_s1     <= vbits_q[idx_in];
				fwd_s1     <= seq_we && (idx_s1 == idx_in);
				fwd_val_s1 <= seq_wdata;
			end else if (item_last) begin
				valid_s1 <= 1'b0;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (writes.ready) begin
				out_valid_q <= 1'b0;
			end

			// item setup on its first cycle
			if (valid_s1 && first_s1) begin
				seq_q   <= seq_mux;
				phase_q <= ph_cur;
				cnt_q   <= '0;
				off_q   <= off_cur;
				if (!first_seen_q) begin
					first_seen_q <= 1'b1;
					first_time_q <= ftime_s1;
				end
				if (new_frag) begin
					packet_open_q   <= 1'b1;
					opened_q        <= !packet_open_q;
					fragment_left_q <= len_new;
					payload_count_q <= packet_open_q ?
						(payload_count_q + 1'b1) : asfp_pkg::PCOUNT_W'(1);
				end
			end

			if (seq_we) begin
				vbits_q[idx_s1] <= 1'b1;
			end

			if (emit) begin
				case (ph_cur)
					PH_FRAG: begin
						off_q <= off_cur + 1'b1;
						if (cnt_cur == LEN_POS_LO && opened_q) begin
							pkt_ms_q <= div_rsp.ms;
						end
						if (cnt_cur == FRAG_LAST) begin
							phase_q <= PH_DATA;
							cnt_q   <= '0;
						end else begin
							phase_q <= PH_FRAG;
							cnt_q   <= cnt_cur + 1'b1;
						end
					end
					PH_DATA: begin
						off_q           <= bu_new;
						bytes_used_q    <= bu_new;
						fragment_left_q <= fl_new;
						frame_offset_q  <= frame_end ? '0 : (frame_offset_q + 1'b1);
						cnt_q           <= '0;
						if (close) begin
							pad_q   <= pad_full[4:0];
							phase_q <= (pad_full == '0) ? PH_PKH : PH_PAD;
						end
					end
					PH_PAD: begin
						off_q <= off_cur + 1'b1;
						if ((cnt_cur + 1'b1) == pad_q) begin
							phase_q <= PH_PKH;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_cur + 1'b1;
						end
					end
					PH_PKH: begin
						if (cnt_cur == PKH_LAST) begin
							packet_open_q <= 1'b0;
						end else begin
							cnt_q <= cnt_cur + 1'b1;
						end
					end
					default: begin
						phase_q <= PH_FRAG;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
